### sv/qvp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the quadric vertex placement block
// no dependencies

package qvp_pkg;

    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int AREA_FRAC_BITS       = 16;
    localparam int SOLVE_BITS           = 20;
    localparam int SOLVE_W              = SOLVE_BITS + 1;
    localparam int COF_W                = 2 * SOLVE_W + 1;
    localparam int ACC_W                = 64;
    localparam int NORMAL_W             = 16;
    localparam int AREA_W               = 32;
    localparam int COORD_W              = 32;
    localparam int SHIFT_W              = 6;
    localparam int EXP_W                = 8;
    localparam int DIV_CNT_W            = 7;
    localparam int DIV_BITS             = 64;
    localparam int IN_DATA_W            = 3 * NORMAL_W + AREA_W + 3 * COORD_W;
    localparam int OUT_DATA_W           = 3 * COORD_W;
    localparam logic [31:0] DET_THR_RESET = 32'd1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL,
        S_AREA,
        S_ACC,
        S_BMUL,
        S_BACC,
        S_LOAD,
        S_NORM,
        S_COF,
        S_DETP,
        S_DETS,
        S_CHK,
        S_NUMP,
        S_NUMS,
        S_DIV_INIT,
        S_DIV,
        S_DIV_END,
        S_OUT
    } t_state;

    typedef struct packed {
        logic cap;
        logic mul;
        logic area;
        logic acc;
        logic bmul;
        logic bacc;
        logic load;
        logic norm;
        logic cof;
        logic detp;
        logic dets;
        logic chk;
        logic nump;
        logic nums;
        logic div_init;
        logic div_step;
        logic div_end;
        logic out_wr;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic norm_done;
        logic sing;
        logic div_done;
        logic coord_last;
        logic out_free;
    } t_stat;

endpackage

### sv/quadric_vertex_placement_top.sv
`timescale 1ns / 1ps
// Quadric vertex placement: each input beat is one (vertex, face) pair and passes through
// an accept state plus a five-step multiply and accumulate sequence. The beat with tlast
// also runs the solve: a load step, a normalize loop (one bit of shift per cycle), the
// adjugate and determinant steps, then three serial divisions of 64 + max(e, 0) quotient
// bits each, with a setup and a finish step around each, where e = 16 - sa + sb. A singular
// quadric skips the divisions. The result sits in an output register, so the next beat is
// taken while it waits.
// depends on qvp_pkg, qvp_ctrl, qvp_dp

module quadric_vertex_placement_top import qvp_pkg::*; #(
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // normal_x, normal_y, normal_z, face_area, vertex_x, vertex_y, vertex_z
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // new_x, new_y, new_z
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // singular
    output logic                  m_axis_tuser,
    input  logic                  i_cfg_we,
    input  logic [31:0]           i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;

    qvp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    qvp_dp #(
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_sing  (m_axis_tuser)
    );

endmodule

### sv/qvp_ctrl.sv
`timescale 1ns / 1ps
// sequencer for accumulation, normalization, solve and division steps
// depends on qvp_pkg

module qvp_ctrl import qvp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_MUL;
            S_MUL:      n_state = S_AREA;
            S_AREA:     n_state = S_ACC;
            S_ACC:      n_state = S_BMUL;
            S_BMUL:     n_state = S_BACC;
            S_BACC:     n_state = i_stat.last ? S_LOAD : S_IDLE;
            S_LOAD:     n_state = S_NORM;
            S_NORM:     if (i_stat.norm_done) n_state = S_COF;
            S_COF:      n_state = S_DETP;
            S_DETP:     n_state = S_DETS;
            S_DETS:     n_state = S_CHK;
            S_CHK:      n_state = i_stat.sing ? S_OUT : S_NUMP;
            S_NUMP:     n_state = S_NUMS;
            S_NUMS:     n_state = S_DIV_INIT;
            S_DIV_INIT: n_state = S_DIV;
            S_DIV:      if (i_stat.div_done) n_state = S_DIV_END;
            S_DIV_END:  n_state = i_stat.coord_last ? S_OUT : S_DIV_INIT;
            S_OUT:      if (i_stat.out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.cap  = i_in_valid;
            end
            S_MUL:      o_cmd.mul      = 1'b1;
            S_AREA:     o_cmd.area     = 1'b1;
            S_ACC:      o_cmd.acc      = 1'b1;
            S_BMUL:     o_cmd.bmul     = 1'b1;
            S_BACC:     o_cmd.bacc     = 1'b1;
            S_LOAD:     o_cmd.load     = 1'b1;
            S_NORM:     o_cmd.norm     = 1'b1;
            S_COF:      o_cmd.cof      = 1'b1;
            S_DETP:     o_cmd.detp     = 1'b1;
            S_DETS:     o_cmd.dets     = 1'b1;
            S_CHK:      o_cmd.chk      = 1'b1;
            S_NUMP:     o_cmd.nump     = 1'b1;
            S_NUMS:     o_cmd.nums     = 1'b1;
            S_DIV_INIT: o_cmd.div_init = 1'b1;
            S_DIV:      o_cmd.div_step = 1'b1;
            S_DIV_END:  o_cmd.div_end  = 1'b1;
            S_OUT:      o_cmd.out_wr   = 1'b1;
            default:    o_cmd          = '0;
        endcase
    end

endmodule

### sv/qvp_dp.sv
`timescale 1ns / 1ps
// datapath: quadric accumulators, normalizer, adjugate solve, serial divider, output register
// depends on qvp_pkg

module qvp_dp import qvp_pkg::*; #(
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic                  i_in_last,
    input  logic                  i_cfg_we,
    input  logic [31:0]           i_cfg_wdata,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic                  o_out_sing
);

    localparam int NFB    = NORMAL_FRAC_BITS;
    localparam int NP_W   = NORMAL_W + COORD_W;
    localparam int SUM_W  = NP_W + 2;
    localparam int D_W    = SUM_W - NFB + 1;
    localparam int DNP_W  = D_W + NORMAL_W;
    localparam int DN_W   = DNP_W - NFB;
    localparam int BP_W   = DN_W + 17;
    localparam int NN_W   = 2 * NORMAL_W;
    localparam int AN_W   = NN_W + AREA_W + 1;

    // input capture
    logic signed [NORMAL_W-1:0] r_n [3];
    logic signed [COORD_W-1:0]  r_p [3];
    logic [AREA_W-1:0]          r_area;
    logic                       r_last;

    logic signed [NP_W-1:0]   r_np  [3];
    logic signed [NN_W-1:0]   r_nn  [6];
    logic signed [D_W-1:0]    r_d;
    logic signed [AN_W-1:0]   r_an  [6];
    logic signed [DNP_W-1:0]  r_dnp [3];
    logic signed [BP_W-1:0]   r_bh  [3];
    logic signed [BP_W-1:0]   r_bl  [3];
    logic signed [ACC_W-1:0]  r_acc [6];
    logic signed [ACC_W-1:0]  r_b   [3];

    // solve
    logic signed [ACC_W-1:0]  r_av [6];
    logic signed [ACC_W-1:0]  r_bv [3];
    logic [ACC_W-1:0]         r_wa;
    logic [ACC_W-1:0]         r_wb;
    logic [SHIFT_W-1:0]       r_sa;
    logic [SHIFT_W-1:0]       r_sb;
    logic signed [COF_W-1:0]  r_c  [6];
    logic signed [ACC_W-1:0]  r_dp [3];
    logic signed [ACC_W-1:0]  r_det;
    logic [ACC_W-1:0]         r_dmag;
    logic                     r_sing;
    logic signed [ACC_W-1:0]  r_nump [9];
    logic signed [ACC_W-1:0]  r_num  [3];
    logic [31:0]              r_thr;

    // divider
    logic [ACC_W-1:0]         r_dnum;
    logic [ACC_W-1:0]         r_rem;
    logic [ACC_W-1:0]         r_quo;
    logic                     r_stk;
    logic                     r_dneg;
    logic [DIV_CNT_W-1:0]     r_cnt;
    logic [1:0]               r_ci;
    logic [COORD_W-1:0]       r_coord [3];

    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data;
    logic                     r_out_sing;

    logic signed [SUM_W-1:0]   sum_v;
    logic signed [SUM_W-1:0]   sum_sh;
    logic signed [DN_W-1:0]    dn [3];
    logic signed [SOLVE_W-1:0] a_s [6];
    logic signed [SOLVE_W-1:0] b_s [3];
    logic [ACC_W-1:0]          wa_v;
    logic [ACC_W-1:0]          wb_v;
    logic [ACC_W-1:0]          dmag_v;
    logic [EXP_W-1:0]          k_v;
    logic [ACC_W-1:0]          need_v;
    logic                      sing_v;
    logic signed [EXP_W-1:0]   exp_v;
    logic [DIV_CNT_W-1:0]      ext_v;
    logic [DIV_CNT_W-1:0]      rsh_v;
    logic signed [ACC_W-1:0]   num_sel;
    logic [ACC_W:0]            trial;
    logic                      qbit;
    logic [ACC_W-1:0]          qs;
    logic [COORD_W-1:0]        coord_v;
    logic                      out_free;

    always_comb begin
        sum_v  = SUM_W'(r_np[0]) + SUM_W'(r_np[1]) + SUM_W'(r_np[2]);
        sum_sh = sum_v >>> NFB;
        for (int i = 0; i < 3; i++) begin
            dn[i]  = DN_W'(r_dnp[i] >>> NFB);
            b_s[i] = SOLVE_W'(r_bv[i]);
        end
        for (int k = 0; k < 6; k++) begin
            a_s[k] = SOLVE_W'(r_av[k]);
        end
        wa_v = '0;
        for (int k = 0; k < 6; k++) begin
            wa_v = wa_v | (r_acc[k][ACC_W-1] ? ~r_acc[k] : r_acc[k]);
        end
        wb_v = '0;
        for (int i = 0; i < 3; i++) begin
            wb_v = wb_v | (r_b[i][ACC_W-1] ? ~r_b[i] : r_b[i]);
        end
    end

    // threshold check, scaled by the normalizing shift
    always_comb begin
        dmag_v = r_det[ACC_W-1] ? (ACC_W'(0) - r_det) : r_det;
        k_v    = EXP_W'(r_sa) + EXP_W'({r_sa, 1'b0});
        if (k_v >= EXP_W'(33)) begin
            need_v = ACC_W'(r_thr != 32'd0);
        end else begin
            need_v = (ACC_W'(r_thr) + (ACC_W'(1) << k_v[5:0]) - ACC_W'(1)) >> k_v[5:0];
        end
        sing_v = (dmag_v == '0) || (dmag_v < need_v);
    end

    always_comb begin
        exp_v   = EXP_W'(AREA_FRAC_BITS) - EXP_W'(r_sa) + EXP_W'(r_sb);
        ext_v   = exp_v[EXP_W-1] ? '0 : exp_v[DIV_CNT_W-1:0];
        rsh_v   = exp_v[EXP_W-1] ? DIV_CNT_W'(-exp_v) : '0;
        num_sel = r_num[r_ci];
        trial   = {r_rem, r_dnum[ACC_W-1]};
        qbit    = trial >= {1'b0, r_dmag};
        qs      = r_quo >> rsh_v;
        if (r_dneg) begin
            coord_v = (r_stk || qs >= ACC_W'(64'h8000_0000)) ? 32'h8000_0000
                                                            : COORD_W'(ACC_W'(0) - qs);
        end else begin
            coord_v = (r_stk || qs > ACC_W'(64'h7fff_ffff)) ? 32'h7fff_ffff : qs[COORD_W-1:0];
        end
        out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            for (int i = 0; i < 3; i++) begin
                r_n[i] <= i_in_data[i*NORMAL_W +: NORMAL_W];
                r_p[i] <= i_in_data[3*NORMAL_W + AREA_W + i*COORD_W +: COORD_W];
            end
            r_area <= i_in_data[3*NORMAL_W +: AREA_W];
            r_last <= i_in_last;
        end
        if (i_cmd.mul) begin
            for (int i = 0; i < 3; i++) begin
                r_np[i] <= r_n[i] * r_p[i];
            end
            r_nn[0] <= r_n[0] * r_n[0];
            r_nn[1] <= r_n[0] * r_n[1];
            r_nn[2] <= r_n[0] * r_n[2];
            r_nn[3] <= r_n[1] * r_n[1];
            r_nn[4] <= r_n[1] * r_n[2];
            r_nn[5] <= r_n[2] * r_n[2];
        end
        if (i_cmd.area) begin
            r_d <= -D_W'(sum_sh);
            for (int k = 0; k < 6; k++) begin
                r_an[k] <= $signed({1'b0, r_area}) * r_nn[k];
            end
        end
        if (i_cmd.acc) begin
            for (int i = 0; i < 3; i++) begin
                r_dnp[i] <= r_d * r_n[i];
            end
        end
        if (i_cmd.bmul) begin
            for (int i = 0; i < 3; i++) begin
                r_bh[i] <= $signed({1'b0, r_area[AREA_W-1:AREA_FRAC_BITS]}) * dn[i];
                r_bl[i] <= $signed({1'b0, r_area[AREA_FRAC_BITS-1:0]}) * dn[i];
            end
        end
        if (i_cmd.load) begin
            for (int k = 0; k < 6; k++) begin
                r_av[k] <= r_acc[k];
            end
            for (int i = 0; i < 3; i++) begin
                r_bv[i] <= r_b[i];
            end
            r_wa <= wa_v;
            r_wb <= wb_v;
            r_sa <= '0;
            r_sb <= '0;
        end
        if (i_cmd.norm) begin
            if (r_wa[ACC_W-1:SOLVE_BITS] != '0) begin
                for (int k = 0; k < 6; k++) begin
                    r_av[k] <= r_av[k] >>> 1;
                end
                r_wa <= r_wa >> 1;
                r_sa <= r_sa + SHIFT_W'(1);
            end
            if (r_wb[ACC_W-1:SOLVE_BITS] != '0) begin
                for (int i = 0; i < 3; i++) begin
                    r_bv[i] <= r_bv[i] >>> 1;
                end
                r_wb <= r_wb >> 1;
                r_sb <= r_sb + SHIFT_W'(1);
            end
        end
        if (i_cmd.cof) begin
            r_c[0] <= a_s[3] * a_s[5] - a_s[4] * a_s[4];
            r_c[1] <= a_s[2] * a_s[4] - a_s[1] * a_s[5];
            r_c[2] <= a_s[1] * a_s[4] - a_s[2] * a_s[3];
            r_c[3] <= a_s[0] * a_s[5] - a_s[2] * a_s[2];
            r_c[4] <= a_s[1] * a_s[2] - a_s[0] * a_s[4];
            r_c[5] <= a_s[0] * a_s[3] - a_s[1] * a_s[1];
        end
        if (i_cmd.detp) begin
            r_dp[0] <= a_s[0] * r_c[0];
            r_dp[1] <= a_s[1] * r_c[1];
            r_dp[2] <= a_s[2] * r_c[2];
        end
        if (i_cmd.dets) begin
            r_det <= r_dp[0] + r_dp[1] + r_dp[2];
        end
        if (i_cmd.chk) begin
            r_sing <= sing_v;
            r_dmag <= dmag_v;
        end
        if (i_cmd.nump) begin
            r_nump[0] <= r_c[0] * b_s[0];
            r_nump[1] <= r_c[1] * b_s[1];
            r_nump[2] <= r_c[2] * b_s[2];
            r_nump[3] <= r_c[1] * b_s[0];
            r_nump[4] <= r_c[3] * b_s[1];
            r_nump[5] <= r_c[4] * b_s[2];
            r_nump[6] <= r_c[2] * b_s[0];
            r_nump[7] <= r_c[4] * b_s[1];
            r_nump[8] <= r_c[5] * b_s[2];
        end
        if (i_cmd.nums) begin
            r_num[0] <= r_nump[0] + r_nump[1] + r_nump[2];
            r_num[1] <= r_nump[3] + r_nump[4] + r_nump[5];
            r_num[2] <= r_nump[6] + r_nump[7] + r_nump[8];
        end
        if (i_cmd.div_init) begin
            r_dnum <= num_sel[ACC_W-1] ? (ACC_W'(0) - num_sel) : num_sel;
            r_dneg <= (num_sel[ACC_W-1] == r_det[ACC_W-1]) && (num_sel != '0);
            r_rem  <= '0;
            r_quo  <= '0;
            r_stk  <= 1'b0;
            r_cnt  <= DIV_CNT_W'(DIV_BITS) + ext_v;
        end
        if (i_cmd.div_step) begin
            r_rem  <= qbit ? ACC_W'(trial - {1'b0, r_dmag}) : trial[ACC_W-1:0];
            r_dnum <= r_dnum << 1;
            r_quo  <= {r_quo[ACC_W-2:0], qbit};
            r_stk  <= r_stk | r_quo[ACC_W-1];
            r_cnt  <= r_cnt - DIV_CNT_W'(1);
        end
        if (i_cmd.div_end) begin
            r_coord[r_ci] <= coord_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci <= '0;
        end else if (i_cmd.nums) begin
            r_ci <= '0;
        end else if (i_cmd.div_end) begin
            r_ci <= r_ci + 2'd1;
        end
    end

    // accumulators, threshold and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_acc[k] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_b[i] <= '0;
            end
            r_thr       <= DET_THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                for (int k = 0; k < 6; k++) begin
                    r_acc[k] <= '0;
                end
                for (int i = 0; i < 3; i++) begin
                    r_b[i] <= '0;
                end
            end else begin
                if (i_cmd.acc) begin
                    for (int k = 0; k < 6; k++) begin
                        r_acc[k] <= r_acc[k] + ACC_W'(r_an[k] >>> (2 * NFB));
                    end
                end
                if (i_cmd.bacc) begin
                    for (int i = 0; i < 3; i++) begin
                        r_b[i] <= r_b[i] + ACC_W'(r_bh[i]) + ACC_W'(r_bl[i] >>> AREA_FRAC_BITS);
                    end
                end
            end
            if (i_cmd.out_wr && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_wr && out_free) begin
            r_out_data <= r_sing ? '0 : {r_coord[2], r_coord[1], r_coord[0]};
            r_out_sing <= r_sing;
        end
    end

    assign o_stat.last       = r_last;
    assign o_stat.norm_done  = (r_wa[ACC_W-1:SOLVE_BITS] == '0) && (r_wb[ACC_W-1:SOLVE_BITS] == '0);
    assign o_stat.sing       = sing_v;
    assign o_stat.div_done   = (r_cnt == DIV_CNT_W'(1));
    assign o_stat.coord_last = (r_ci == 2'd2);
    assign o_stat.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_sing  = r_out_sing;

endmodule

### sv/qvp_checker.sv
`timescale 1ns / 1ps
// port-level checks for the quadric vertex placement block, bound to the top level
// depends on qvp_pkg

module qvp_checker import qvp_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser,
    input logic                  i_cfg_we,
    input logic [31:0]           i_cfg_wdata
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("singular beat with nonzero coordinates");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken in back-to-back cycles");

    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared one cycle after an input beat");

endmodule

bind quadric_vertex_placement_top qvp_checker u_qvp_checker (.*);

### verif/quadric_vertex_placement_checker.sv
`timescale 1ns / 1ps
// watches the input, output and threshold ports, predicts each solved vertex and compares
// depends on qvp_pkg for the stream widths

module quadric_vertex_placement_checker import qvp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic                  i_in_last,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [OUT_DATA_W-1:0] i_out_data,
    input  logic                  i_out_sing,
    input  logic                  i_cfg_we,
    input  logic [31:0]           i_cfg_wdata,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int NFB = 14;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        sing;
    } t_vertex;

    t_vertex     vertex_q[$];
    longint      quad_xx, quad_xy, quad_xz, quad_yy, quad_yz, quad_zz;
    longint      lin_x, lin_y, lin_z;
    logic [31:0] threshold;

    function automatic longint unsigned fold(longint v);
        return v < 0 ? ~v : v;
    endfunction

    function automatic int fit_width(longint unsigned all);
        int len;
        len = 0;
        while (len < 64 && (all >> len) != 0) len++;
        return len > SOLVE_BITS ? len - SOLVE_BITS : 0;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? 64'd0 - longint'(v) : v;
    endfunction

    function automatic longint unsigned scaled_div(longint unsigned n, longint unsigned d,
                                                   int e);
        longint unsigned q, r;
        q = n / d;
        r = n % d;
        if (e < 0) return (-e >= 64) ? 0 : (q >> (-e));
        for (int i = 0; i < e; i++) begin
            if (q > (64'd1 << 32)) break;
            q = q << 1;
            r = r << 1;
            if (r >= d) begin
                r = r - d;
                q++;
            end
        end
        return q;
    endfunction

    function automatic logic [31:0] clamp_coord(logic neg, longint unsigned q);
        if (neg) begin
            if (q >= (64'd1 << 31)) return 32'h8000_0000;
            return 32'(64'd0 - q);
        end
        if (q > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return 32'(q);
    endfunction

    function automatic t_vertex solve_vertex(longint a[6], longint b[3], logic [31:0] thr);
        t_vertex         v;
        int              sa, sb, k, e;
        longint          c[6], num[3], det;
        longint unsigned all, dmag, need;
        all = 0;
        for (int i = 0; i < 6; i++) all |= fold(a[i]);
        sa = fit_width(all);
        all = 0;
        for (int i = 0; i < 3; i++) all |= fold(b[i]);
        sb = fit_width(all);
        for (int i = 0; i < 6; i++) a[i] = a[i] >>> sa;
        for (int i = 0; i < 3; i++) b[i] = b[i] >>> sb;
        c[0] = a[3] * a[5] - a[4] * a[4];
        c[1] = a[2] * a[4] - a[1] * a[5];
        c[2] = a[1] * a[4] - a[2] * a[3];
        c[3] = a[0] * a[5] - a[2] * a[2];
        c[4] = a[1] * a[2] - a[0] * a[4];
        c[5] = a[0] * a[3] - a[1] * a[1];
        det = a[0] * c[0] + a[1] * c[1] + a[2] * c[2];
        dmag = magnitude(det);
        k = 3 * sa;
        if (k >= 33) need = (thr != 0) ? 1 : 0;
        else need = ({32'd0, thr} + (64'd1 << k) - 1) >> k;
        v = '{32'd0, 32'd0, 32'd0, 1'b1};
        if (dmag == 0 || dmag < need) return v;
        num[0] = c[0] * b[0] + c[1] * b[1] + c[2] * b[2];
        num[1] = c[1] * b[0] + c[3] * b[1] + c[4] * b[2];
        num[2] = c[2] * b[0] + c[4] * b[1] + c[5] * b[2];
        e = AREA_FRAC_BITS - sa + sb;
        v.x = clamp_coord(((num[0] < 0) == (det < 0)) && num[0] != 0,
                          scaled_div(magnitude(num[0]), dmag, e));
        v.y = clamp_coord(((num[1] < 0) == (det < 0)) && num[1] != 0,
                          scaled_div(magnitude(num[1]), dmag, e));
        v.z = clamp_coord(((num[2] < 0) == (det < 0)) && num[2] != 0,
                          scaled_div(magnitude(num[2]), dmag, e));
        v.sing = 1'b0;
        return v;
    endfunction

    task automatic add_face(logic [IN_DATA_W-1:0] d, logic last);
        longint n[3], p[3], area, ah, al, sum, pd, dn, bt[3], a[6], b[3];
        for (int i = 0; i < 3; i++) begin
            n[i] = longint'($signed(d[16*i +: 16]));
            p[i] = longint'($signed(d[80 + 32*i +: 32]));
        end
        area = longint'({32'd0, d[79:48]});
        ah = area >> 16;
        al = area & 64'hFFFF;
        sum = n[0] * p[0] + n[1] * p[1] + n[2] * p[2];
        pd = -(sum >>> NFB);
        quad_xx += (area * (n[0] * n[0])) >>> (2 * NFB);
        quad_xy += (area * (n[0] * n[1])) >>> (2 * NFB);
        quad_xz += (area * (n[0] * n[2])) >>> (2 * NFB);
        quad_yy += (area * (n[1] * n[1])) >>> (2 * NFB);
        quad_yz += (area * (n[1] * n[2])) >>> (2 * NFB);
        quad_zz += (area * (n[2] * n[2])) >>> (2 * NFB);
        for (int i = 0; i < 3; i++) begin
            dn = (pd * n[i]) >>> NFB;
            bt[i] = ah * dn + ((al * dn) >>> AREA_FRAC_BITS);
        end
        lin_x += bt[0];
        lin_y += bt[1];
        lin_z += bt[2];
        if (last) begin
            a = '{quad_xx, quad_xy, quad_xz, quad_yy, quad_yz, quad_zz};
            b = '{lin_x, lin_y, lin_z};
            vertex_q.push_back(solve_vertex(a, b, threshold));
            {quad_xx, quad_xy, quad_xz, quad_yy, quad_yz, quad_zz} = '0;
            {lin_x, lin_y, lin_z} = '0;
        end
    endtask

    task automatic check_vertex();
        t_vertex want;
        if (vertex_q.size() == 0) begin
            $display("%0t: unexpected result beat, actual %h sing %b", $time, i_out_data,
                     i_out_sing);
            o_errors++;
            return;
        end
        want = vertex_q.pop_front();
        if (i_out_data[31:0] !== want.x) begin
            $display("%0t: new_x expected %h actual %h", $time, want.x, i_out_data[31:0]);
            o_errors++;
        end
        if (i_out_data[63:32] !== want.y) begin
            $display("%0t: new_y expected %h actual %h", $time, want.y, i_out_data[63:32]);
            o_errors++;
        end
        if (i_out_data[95:64] !== want.z) begin
            $display("%0t: new_z expected %h actual %h", $time, want.z, i_out_data[95:64]);
            o_errors++;
        end
        if (i_out_sing !== want.sing) begin
            $display("%0t: singular expected %b actual %b", $time, want.sing, i_out_sing);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        threshold = DET_THR_RESET;
        {quad_xx, quad_xy, quad_xz, quad_yy, quad_yz, quad_zz} = '0;
        {lin_x, lin_y, lin_z} = '0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) check_vertex();
            if (i_in_valid && i_in_ready) add_face(i_in_data, i_in_last);
            if (i_cfg_we) threshold = i_cfg_wdata;
        end
    end

    assign o_pending = vertex_q.size();

endmodule

### verif/quadric_vertex_placement_top_test.sv
`timescale 1ns / 1ps
// stimulus and verdict for quadric_vertex_placement_top: face runs under several thresholds
// depends on qvp_pkg, quadric_vertex_placement_top and quadric_vertex_placement_checker

module quadric_vertex_placement_top_test import qvp_pkg::*;;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [31:0]           i_cfg_wdata = '0;
    int                    errors;
    int                    pending;
    int                    cycles = 0;
    bit                    quiet = 1'b0;
    int                    sink_stall = 0;

    always #4 i_clk = ~i_clk;

    quadric_vertex_placement_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    quadric_vertex_placement_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_last(s_axis_tlast),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_sing(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1_500_000) begin
            $display("quadric_vertex_placement_top: mismatch");
            $finish;
        end
    end

    // sink stalls in bursts
    always @(posedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            sink_stall <= $urandom_range(1, 13) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_face(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                             logic [31:0] area, logic [31:0] vx, logic [31:0] vy,
                             logic [31:0] vz, logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {vz, vy, vx, area, nz, ny, nx};
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] rand_normal();
        if ($urandom_range(0, 15) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endfunction

    function automatic logic [31:0] rand_area();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0000_FFFF);
            default: return $urandom_range(0, 32'h00FF_FFFF);
        endcase
    endfunction

    task automatic random_runs(int faces);
        int n, len;
        n = 0;
        while (n < faces) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_face(rand_normal(), rand_normal(), rand_normal(), rand_area(),
                          rand_coord(), rand_coord(), rand_coord(), i == len - 1);
            n += len;
        end
    endtask

    task automatic write_threshold(logic [31:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // three axis planes, well conditioned
        send_face(16'sd16384, 16'sd0, 16'sd0, 32'h0001_0000, 32'h0001_0000, 0, 0, 0);
        send_face(16'sd0, 16'sd16384, 16'sd0, 32'h0001_0000, 0, 32'hFFFE_0000, 0, 0);
        send_face(16'sd0, 16'sd0, 16'sd16384, 32'h0001_0000, 0, 0, 32'h0003_0000, 1);
        // one plane only, singular
        send_face(16'sd16384, 16'sd0, 16'sd0, 32'h0002_0000, 32'h0001_0000, 0, 0, 1);
        // zero normal and zero area
        send_face(16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1);
        // extremes of every field
        send_face(-16'sd16384, -16'sd16384, -16'sd16384, 32'hFFFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_face(16'sd16384, -16'sd16384, 16'sd16384, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_face(16'h8000, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1);
        // large offsets that saturate the position
        send_face(16'sd16384, 0, 0, 32'h0000_0001, 32'h7FFF_FFFF, 0, 0, 0);
        send_face(0, 16'sd16384, 0, 32'h0000_0001, 0, 32'h8000_0000, 0, 0);
        send_face(0, 0, 16'sd16384, 32'h0000_0001, 0, 0, 32'h7FFF_FFFF, 0);
        send_face(16'sd11585, 16'sd11585, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1);
        // accumulation over six heavy faces in one run
        for (int i = 0; i < 6; i++)
            send_face(16'h8000, 16'h8000, 16'h8000, 32'hFFFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, i == 5);

        random_runs(250);
        write_threshold(32'd0);
        send_face(16'sd16384, 0, 0, 32'h0001_0000, 0, 0, 0, 1);
        random_runs(250);
        write_threshold(32'hFFFF_FFFF);
        random_runs(250);
        write_threshold($urandom_range(2, 32'h00FF_FFFF));
        random_runs(250);
        write_threshold($urandom);
        random_runs(150);
        write_threshold(32'd1);
        quiet = 1'b1;
        random_runs(130);

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (errors == 0)
            $display("quadric_vertex_placement_top: match");
        else
            $display("quadric_vertex_placement_top: mismatch");
        $finish;
    end

endmodule
